// File: rtl/tswm_pkg.sv
// ----------------------------------------------------------------------------
// Three-way sine crossfade mixer package
// Shared constants, register and source codes, and the sine table builder.
// ----------------------------------------------------------------------------
package tswm_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int SINE_ENTRIES_DEF = 256;

  localparam int MOD_BITS      = 17;
  localparam int BAL_BITS      = 16;
  localparam int GAIN_BITS     = 16;
  localparam int SRC_BITS      = 2;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [BAL_BITS-1:0]  BAL_RESET = 16'h8000;
  localparam logic [BAL_BITS:0]    BAL_HALF  = 17'h08000;
  localparam logic [BAL_BITS:0]    BAL_FULL  = 17'h10000;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE  = 16'h8000;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FIXED_BALANCE  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BALANCE_SOURCE = 1'b1;

  localparam logic [SRC_BITS-1:0] SRC_FIXED    = 2'd0;
  localparam logic [SRC_BITS-1:0] SRC_UNIPOLAR = 2'd1;
  localparam logic [SRC_BITS-1:0] SRC_BIPOLAR  = 2'd2;

  localparam int PHASE_FRAC_BITS = 15;
  localparam int PHASE_ROUND     = 16384;

  localparam int MAG_EXTRA    = 18;
  localparam int ROUND_SHIFT  = 15;
  localparam int ROUND_BIAS   = 49152;
  localparam int PIPE_LATENCY = 9;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Floor quotient by shift and subtract, used while the sine table is built.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine of a Q2.30 angle by a Taylor series up to x^15, rounded to Q1.15.
  function automatic logic [GAIN_BITS-1:0] sine_q15(input longint unsigned x);
    longint unsigned t;
    longint          acc;
    longint unsigned v;
    t   = x;
    acc = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = udiv64(t, 64'((2 * n) * (2 * n + 1)));
      if (n[0]) begin
        acc = acc - longint'(t);
      end else begin
        acc = acc + longint'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = ((unsigned'(acc) * 64'd32768) + 64'd536870912) >> 30;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return v[GAIN_BITS-1:0];
  endfunction

endpackage

// File: rtl/tswm_balance.sv
// ----------------------------------------------------------------------------
// Balance select stage
// Holds the configuration registers and picks the Q0.16 balance of each item.
// ----------------------------------------------------------------------------
module tswm_balance import tswm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic                          valid_i,
  input  logic signed [SAMPLE_BITS-1:0] s1_i,
  input  logic signed [SAMPLE_BITS-1:0] s2_i,
  input  logic signed [SAMPLE_BITS-1:0] s3_i,
  input  logic signed [MOD_BITS-1:0]    mod_i,
  output logic                          valid_o,
  output logic [BAL_BITS-1:0]           bal_o,
  output logic signed [SAMPLE_BITS-1:0] s1_o,
  output logic signed [SAMPLE_BITS-1:0] s2_o,
  output logic signed [SAMPLE_BITS-1:0] s3_o
);

  logic [BAL_BITS-1:0]           fixed_q, fixed_d;
  logic [SRC_BITS-1:0]           src_q, src_d;
  logic                          vld_q;
  logic [BAL_BITS-1:0]           bal_q, bal_d;
  logic signed [SAMPLE_BITS-1:0] s1_q, s2_q, s3_q;
  logic signed [MOD_BITS:0]      bip;

  always_comb begin
    fixed_d = fixed_q;
    src_d   = src_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FIXED_BALANCE: begin
          fixed_d = cfg_data_i[BAL_BITS-1:0];
        end
        CFG_BALANCE_SOURCE: begin
          src_d = cfg_data_i[SRC_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    bip = $signed({mod_i[MOD_BITS-1], mod_i}) + $signed({1'b0, BAL_HALF});
    case (src_q)
      SRC_UNIPOLAR: begin
        bal_d = mod_i[MOD_BITS-1] ? '0 : mod_i[BAL_BITS-1:0];
      end
      SRC_BIPOLAR: begin
        if (bip[MOD_BITS]) begin
          bal_d = '0;
        end else if (bip[MOD_BITS-1]) begin
          bal_d = '1;
        end else begin
          bal_d = bip[BAL_BITS-1:0];
        end
      end
      default: begin
        bal_d = fixed_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_q <= BAL_RESET;
      src_q   <= SRC_FIXED;
      vld_q   <= 1'b0;
    end else begin
      fixed_q <= fixed_d;
      src_q   <= src_d;
      vld_q   <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bal_q <= bal_d;
    s1_q  <= s1_i;
    s2_q  <= s2_i;
    s3_q  <= s3_i;
  end

  assign valid_o = vld_q;
  assign bal_o   = bal_q;
  assign s1_o    = s1_q;
  assign s2_o    = s2_q;
  assign s3_o    = s3_q;

endmodule

// File: rtl/tswm_gain.sv
// ----------------------------------------------------------------------------
// Gain lookup stages
// Turns the balance into two table indexes, then reads the three gains.
// ----------------------------------------------------------------------------
module tswm_gain import tswm_pkg::*; #(
  parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [BAL_BITS-1:0]           bal_i,
  input  logic signed [SAMPLE_BITS-1:0] s1_i,
  input  logic signed [SAMPLE_BITS-1:0] s2_i,
  input  logic signed [SAMPLE_BITS-1:0] s3_i,
  output logic                          valid_o,
  output logic [GAIN_BITS-1:0]          g1_o,
  output logic [GAIN_BITS-1:0]          g2_o,
  output logic [GAIN_BITS-1:0]          g3_o,
  output logic signed [SAMPLE_BITS-1:0] s1_o,
  output logic signed [SAMPLE_BITS-1:0] s2_o,
  output logic signed [SAMPLE_BITS-1:0] s3_o
);

  localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int PW = BAL_BITS + IW + 1;

  logic [GAIN_BITS-1:0] rom [SINE_TABLE_ENTRIES+1];

  for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_rom
    localparam longint unsigned X =
      (HALF_PI_Q30 * k + SINE_TABLE_ENTRIES / 2) / SINE_TABLE_ENTRIES;
    localparam logic [GAIN_BITS-1:0] V = sine_q15(X);
    assign rom[k] = V;
  end

  logic [BAL_BITS-1:0]           ph_c, ph_2;
  logic [PW-1:0]                 prod_c, prod_2;
  logic                          lo_d, hi_d;
  logic [IW-1:0]                 ic_d, i2_d;

  logic                          v2_q;
  logic                          lo_q, hi_q;
  logic [IW-1:0]                 ic_q, i2_q;
  logic signed [SAMPLE_BITS-1:0] s1_2q, s2_2q, s3_2q;

  logic                          v3_q;
  logic [GAIN_BITS-1:0]          g1_q, g2_q, g3_q, g1_d, g2_d, g3_d;
  logic signed [SAMPLE_BITS-1:0] s1_3q, s2_3q, s3_3q;

  always_comb begin
    lo_d = ({1'b0, bal_i} < BAL_HALF);
    hi_d = ({1'b0, bal_i} > BAL_HALF);
    ph_c = lo_d ? BAL_BITS'(BAL_HALF - {1'b0, bal_i})
                : BAL_BITS'({1'b0, bal_i} - BAL_HALF);
    ph_2 = hi_d ? BAL_BITS'(BAL_FULL - {1'b0, bal_i}) : bal_i;
    prod_c = PW'(ph_c) * PW'(SINE_TABLE_ENTRIES) + PW'(PHASE_ROUND);
    prod_2 = PW'(ph_2) * PW'(SINE_TABLE_ENTRIES) + PW'(PHASE_ROUND);
    ic_d = prod_c[PHASE_FRAC_BITS +: IW];
    i2_d = prod_2[PHASE_FRAC_BITS +: IW];
  end

  always_comb begin
    g1_d = lo_q ? rom[ic_q] : '0;
    g3_d = hi_q ? rom[ic_q] : '0;
    g2_d = rom[i2_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    ic_q  <= ic_d;
    i2_q  <= i2_d;
    s1_2q <= s1_i;
    s2_2q <= s2_i;
    s3_2q <= s3_i;
    g1_q  <= g1_d;
    g2_q  <= g2_d;
    g3_q  <= g3_d;
    s1_3q <= s1_2q;
    s2_3q <= s2_2q;
    s3_3q <= s3_2q;
  end

  assign valid_o = v3_q;
  assign g1_o    = g1_q;
  assign g2_o    = g2_q;
  assign g3_o    = g3_q;
  assign s1_o    = s1_3q;
  assign s2_o    = s2_3q;
  assign s3_o    = s3_3q;

  // A balance of exactly one half passes only the middle channel, at full gain.
  a_half_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !lo_q && !hi_q) |=> (g1_q == '0 && g3_q == '0 && g2_q == GAIN_ONE))
    else $error("half balance does not select the middle channel alone");

endmodule

// File: rtl/tswm_mac.sv
// ----------------------------------------------------------------------------
// Weighted sum stages
// Multiplies each sample by its gain, adds, and splits the sum into sign and
// magnitude.
// ----------------------------------------------------------------------------
module tswm_mac import tswm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [SAMPLE_BITS-1:0]     s1_i,
  input  logic signed [SAMPLE_BITS-1:0]     s2_i,
  input  logic signed [SAMPLE_BITS-1:0]     s3_i,
  input  logic [GAIN_BITS-1:0]              g1_i,
  input  logic [GAIN_BITS-1:0]              g2_i,
  input  logic [GAIN_BITS-1:0]              g3_i,
  output logic                              valid_o,
  output logic                              neg_o,
  output logic [SAMPLE_BITS+MAG_EXTRA-1:0]  mag_o
);

  localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int MW = SAMPLE_BITS + MAG_EXTRA;
  localparam int SW = MW + 1;

  logic                 v4_q, v5_q, v6_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p1_d, p2_d, p3_d;
  logic signed [SW-1:0] sum_q, sum_d, neg_sum;
  logic                 neg_q, neg_d;
  logic [MW-1:0]        mag_q, mag_d;

  always_comb begin
    p1_d = s1_i * $signed({1'b0, g1_i});
    p2_d = s2_i * $signed({1'b0, g2_i});
    p3_d = s3_i * $signed({1'b0, g3_i});
    sum_d = SW'(p1_q) + SW'(p2_q) + SW'(p3_q);
    neg_sum = -sum_q;
    neg_d = sum_q[SW-1];
    mag_d = neg_d ? neg_sum[MW-1:0] : sum_q[MW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    p3_q  <= p3_d;
    sum_q <= sum_d;
    neg_q <= neg_d;
    mag_q <= mag_d;
  end

  assign valid_o = v6_q;
  assign neg_o   = neg_q;
  assign mag_o   = mag_q;

endmodule

// File: rtl/tswm_div3.sv
// ----------------------------------------------------------------------------
// Scale, round and saturate stages
// Rounds the magnitude by 3 * 2^15, divides by three through a reciprocal
// multiplication, then restores the sign and saturates.
// ----------------------------------------------------------------------------
module tswm_div3 import tswm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic                              neg_i,
  input  logic [SAMPLE_BITS+MAG_EXTRA-1:0]  mag_i,
  output logic                              valid_o,
  output logic [SAMPLE_BITS-1:0]            mixed_o
);

  localparam int              MW    = SAMPLE_BITS + MAG_EXTRA;
  localparam int              FW    = MW + 1 - ROUND_SHIFT;
  localparam int              YW    = SAMPLE_BITS + 1;
  localparam int              RW    = YW + 1;
  localparam int              PW    = 2 * YW;
  localparam longint          YMAX  = 3 * (longint'(1) << (SAMPLE_BITS - 1));
  localparam longint unsigned RECIP = ((64'd1 << RW) + 64'd2) / 64'd3;

  logic [MW:0]            ysum;
  logic [FW-1:0]          yfull;
  logic [YW-1:0]          y_d;
  logic [PW-1:0]          prod;
  logic [YW-1:0]          qt_d;

  logic                   vld1_q, vld2_q, out_vld_q;
  logic                   neg1_q, neg2_q;
  logic [YW-1:0]          y1_q, y2_q, qt_q;
  logic [SAMPLE_BITS-1:0] mixed_q, mixed_d;
  logic [YW:0]            neg_qt;

  always_comb begin
    ysum  = (MW + 1)'(mag_i) + (MW + 1)'(ROUND_BIAS);
    yfull = ysum[MW:ROUND_SHIFT];
    y_d   = (yfull > FW'(YMAX)) ? YW'(YMAX) : yfull[YW-1:0];
  end

  always_comb begin
    prod = PW'(y1_q) * PW'(RECIP);
    qt_d = {1'b0, prod[PW-1:RW]};
  end

  always_comb begin
    neg_qt = -{1'b0, qt_q};
    if (neg2_q) begin
      mixed_d = neg_qt[SAMPLE_BITS-1:0];
    end else if (|qt_q[YW-1:SAMPLE_BITS-1]) begin
      mixed_d = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end else begin
      mixed_d = qt_q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      vld1_q    <= valid_i;
      vld2_q    <= vld1_q;
      out_vld_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q  <= neg_i;
    y1_q    <= y_d;
    neg2_q  <= neg1_q;
    y2_q    <= y1_q;
    qt_q    <= qt_d;
    mixed_q <= mixed_d;
  end

  assign valid_o = out_vld_q;
  assign mixed_o = mixed_q;

  // The reciprocal product must give the floor of the dividend over three.
  a_div_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld2_q |-> (((YW + 2)'(qt_q) * (YW + 2)'(3)) <= (YW + 2)'(y2_q)) &&
               (((YW + 2)'(y2_q) - (YW + 2)'(qt_q) * (YW + 2)'(3)) < (YW + 2)'(3)))
    else $error("division by three produced a wrong quotient");

endmodule

// File: rtl/three_way_sine_crossfade_mixer.sv
// ----------------------------------------------------------------------------
// Three-way sine crossfade mixer
// Equal-power crossfade of three sample channels under a balance value,
// scaled by one third, rounded and saturated.
//
// Channel   Handshake                 Payload
// input     start_i, busy_o           sample_one_i, sample_two_i,
//                                     sample_three_i, modulation_value_i
// result    done_o (one-cycle strobe) mixed_sample_o
// config    cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item is accepted every cycle; busy_o stays low.
// The pipeline has one balance stage, two gain stages, three
// multiply-add stages and three scale stages.
// Reset clears the valid bits and loads fixed_balance 32768, fixed source.
// The pipeline never stalls: each result is shown on done_o for one cycle.
// ----------------------------------------------------------------------------
module three_way_sine_crossfade_mixer import tswm_pkg::*; #(
  parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_one_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_two_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_three_i,
  input  logic signed [MOD_BITS-1:0]    modulation_value_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] mixed_sample_o
);

  localparam int LATENCY = PIPE_LATENCY;
  localparam int MW      = SAMPLE_BITS + MAG_EXTRA;

  logic                          b_vld;
  logic [BAL_BITS-1:0]           b_bal;
  logic signed [SAMPLE_BITS-1:0] b_s1, b_s2, b_s3;

  logic                          g_vld;
  logic [GAIN_BITS-1:0]          g_g1, g_g2, g_g3;
  logic signed [SAMPLE_BITS-1:0] g_s1, g_s2, g_s3;

  logic                          m_vld;
  logic                          m_neg;
  logic [MW-1:0]                 m_mag;

  logic [SAMPLE_BITS-1:0]        mixed;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  tswm_balance #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_balance (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .valid_i     (start_i),
    .s1_i        (sample_one_i),
    .s2_i        (sample_two_i),
    .s3_i        (sample_three_i),
    .mod_i       (modulation_value_i),
    .valid_o     (b_vld),
    .bal_o       (b_bal),
    .s1_o        (b_s1),
    .s2_o        (b_s2),
    .s3_o        (b_s3)
  );

  tswm_gain #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
  ) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_vld),
    .bal_i   (b_bal),
    .s1_i    (b_s1),
    .s2_i    (b_s2),
    .s3_i    (b_s3),
    .valid_o (g_vld),
    .g1_o    (g_g1),
    .g2_o    (g_g2),
    .g3_o    (g_g3),
    .s1_o    (g_s1),
    .s2_o    (g_s2),
    .s3_o    (g_s3)
  );

  tswm_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_vld),
    .s1_i    (g_s1),
    .s2_i    (g_s2),
    .s3_i    (g_s3),
    .g1_i    (g_g1),
    .g2_i    (g_g2),
    .g3_i    (g_g3),
    .valid_o (m_vld),
    .neg_o   (m_neg),
    .mag_o   (m_mag)
  );

  tswm_div3 #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_vld),
    .neg_i   (m_neg),
    .mag_i   (m_mag),
    .valid_o (done_o),
    .mixed_o (mixed)
  );

  assign mixed_sample_o = $signed(mixed);

  a_item_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LATENCY done_o)
    else $error("accepted item produced no result after the pipeline latency");

  a_done_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("result strobe without a matching accepted item");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Three-way sine crossfade mixer testbench
// Sends sample frames under every balance source and several fixed balances,
// predicts each mixed sample from a locally built sine table and checks the
// results in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tswm_pkg::*;

  localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
  localparam int SINE_ENTRIES = SINE_ENTRIES_DEF;
  localparam int PIPE_LAT     = PIPE_LATENCY;
  localparam int DRAIN_CYCLES = PIPE_LAT + 5;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 75;

  localparam longint GAIN_UNITY  = 32768;
  localparam longint BAL_TOP     = 65535;
  localparam longint MIX_DIVISOR = 3 * GAIN_UNITY;
  localparam longint MIX_BIAS    = MIX_DIVISOR / 2;
  localparam longint OUT_MAX     = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint OUT_MIN     = -OUT_MAX - 1;

  localparam logic [SRC_BITS-1:0] SRC_SPARE = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct {
    logic signed [SAMPLE_W-1:0] one;
    logic signed [SAMPLE_W-1:0] two;
    logic signed [SAMPLE_W-1:0] three;
    logic signed [MOD_BITS-1:0] mod;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [SAMPLE_W-1:0] sample_one_i = '0;
  logic signed [SAMPLE_W-1:0] sample_two_i = '0;
  logic signed [SAMPLE_W-1:0] sample_three_i = '0;
  logic signed [MOD_BITS-1:0] modulation_value_i = '0;
  logic done_o;
  logic signed [SAMPLE_W-1:0] mixed_sample_o;

  frame_t frame_q[$];
  logic [SAMPLE_W-1:0] mix_expect_q[$];
  longint unsigned sine_rom[0:SINE_ENTRIES];

  logic [BAL_BITS-1:0] bal_reg;
  logic [SRC_BITS-1:0] src_reg;
  int burst_left;
  int gap_left;
  int idle_cycles = 0;
  int errors = 0;
  int items_taken = 0;
  int results_seen = 0;
  int cfg_writes = 0;

  three_way_sine_crossfade_mixer #(
    .SAMPLE_BITS(SAMPLE_W),
    .SINE_TABLE_ENTRIES(SINE_ENTRIES)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .start_i(start_i),
    .busy_o(busy_o),
    .sample_one_i(sample_one_i),
    .sample_two_i(sample_two_i),
    .sample_three_i(sample_three_i),
    .modulation_value_i(modulation_value_i),
    .done_o(done_o),
    .mixed_sample_o(mixed_sample_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void build_sine_rom();
    longint unsigned ang;
    longint unsigned term;
    longint unsigned rounded;
    longint series;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      ang = (HALF_PI_Q30 * longint'(k) + SINE_ENTRIES / 2) / SINE_ENTRIES;
      term = ang;
      series = longint'(ang);
      for (int n = 1; n <= 7; n++) begin
        term = (term * ang) >> 30;
        term = (term * ang) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        series = (n % 2 == 1) ? series - longint'(term) : series + longint'(term);
      end
      if (series < 0) begin
        series = 0;
      end
      rounded = (longint'(series) * 64'd32768 + (64'd1 << 29)) >> 30;
      sine_rom[k] = (rounded > GAIN_UNITY) ? GAIN_UNITY : rounded;
    end
  endfunction

  function automatic longint quarter_gain(input longint phase);
    longint idx;
    idx = (phase * SINE_ENTRIES + GAIN_UNITY / 2) >>> 15;
    if (idx > SINE_ENTRIES) begin
      idx = SINE_ENTRIES;
    end
    return longint'(sine_rom[idx]);
  endfunction

  function automatic logic [SAMPLE_W-1:0] mix_predict(input frame_t f);
    longint bal;
    longint g_one;
    longint g_two;
    longint g_three;
    longint acc;
    longint q;
    case (src_reg)
      SRC_UNIPOLAR: bal = longint'(f.mod);
      SRC_BIPOLAR:  bal = longint'(f.mod) + GAIN_UNITY;
      default:      bal = longint'(bal_reg);
    endcase
    if (bal < 0) begin
      bal = 0;
    end
    if (bal > BAL_TOP) begin
      bal = BAL_TOP;
    end
    g_one = (bal < GAIN_UNITY) ? quarter_gain(GAIN_UNITY - bal) : 0;
    g_two = (bal <= GAIN_UNITY) ? quarter_gain(bal) : quarter_gain(2 * GAIN_UNITY - bal);
    g_three = (bal > GAIN_UNITY) ? quarter_gain(bal - GAIN_UNITY) : 0;
    acc = longint'(f.one) * g_one + longint'(f.two) * g_two + longint'(f.three) * g_three;
    if (acc < 0) begin
      q = -((-acc + MIX_BIAS) / MIX_DIVISOR);
    end else begin
      q = (acc + MIX_BIAS) / MIX_DIVISOR;
    end
    if (q > OUT_MAX) begin
      q = OUT_MAX;
    end
    if (q < OUT_MIN) begin
      q = OUT_MIN;
    end
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic void queue_frame(input logic signed [SAMPLE_W-1:0] a,
                                      input logic signed [SAMPLE_W-1:0] b,
                                      input logic signed [SAMPLE_W-1:0] c,
                                      input logic signed [MOD_BITS-1:0] m);
    frame_t f;
    f.one = a;
    f.two = b;
    f.three = c;
    f.mod = m;
    frame_q.push_back(f);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [MOD_BITS-1:0] rand_mod(input logic [SRC_BITS-1:0] src);
    logic signed [15:0] bip;
    bip = 16'($urandom());
    if ($urandom_range(0, 7) == 0) begin
      return MOD_BITS'($urandom());
    end
    case (src)
      SRC_UNIPOLAR: return MOD_BITS'($urandom_range(0, 65535));
      SRC_BIPOLAR:  return MOD_BITS'(bip);
      default:      return MOD_BITS'($urandom());
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (frame_q.size() != 0 || start_i || mix_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      bal_reg = BAL_RESET;
      src_reg = SRC_FIXED;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_writes++;
        case (cfg_index_i)
          CFG_FIXED_BALANCE:  bal_reg = cfg_data_i[BAL_BITS-1:0];
          CFG_BALANCE_SOURCE: src_reg = cfg_data_i[SRC_BITS-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        mix_expect_q.push_back(mix_predict('{sample_one_i, sample_two_i, sample_three_i,
                                             modulation_value_i}));
        items_taken++;
      end
      if (!start_i || !busy_o) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (frame_q.size() != 0) begin
          frame_t f;
          f = frame_q.pop_front();
          sample_one_i <= f.one;
          sample_two_i <= f.two;
          sample_three_i <= f.three;
          modulation_value_i <= f.mod;
          start_i <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic [SAMPLE_W-1:0] want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (mix_expect_q.size() == 0) begin
        $display("%0t ns: unexpected mixed_sample, expected none, got %0d",
                 $time, mixed_sample_o);
        errors++;
      end else begin
        want = mix_expect_q.pop_front();
        if (mixed_sample_o !== want) begin
          $display("%0t ns: mixed_sample expected %0d, got %0d",
                   $time, $signed(want), mixed_sample_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no activity for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [SRC_BITS-1:0] src;
    logic [BAL_BITS-1:0] bal;
    build_sine_rom();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The reset balance of one half passes only the second channel.
    queue_frame(SMP_MAX, SMP_MAX, SMP_MAX, '0);
    queue_frame(SMP_MIN, SMP_MIN, SMP_MIN, '0);
    queue_frame(SMP_MIN, -2, SMP_MAX, '1);
    queue_frame(1, 2, -1, '0);
    wait_drained();

    write_reg(CFG_BALANCE_SOURCE, CFG_DATA_BITS'(SRC_UNIPOLAR));
    @(negedge clk_i);
    queue_frame(SMP_MAX, SMP_MIN, SMP_MAX, 17'sd0);
    queue_frame(SMP_MAX, SMP_MIN, SMP_MAX, 17'sd65535);
    queue_frame(SMP_MIN, SMP_MAX, SMP_MIN, 17'sd32767);
    queue_frame(SMP_MIN, SMP_MAX, SMP_MIN, 17'sd32768);
    queue_frame(SMP_MAX, SMP_MAX, SMP_MAX, 17'sd32769);
    queue_frame(SMP_MAX, SMP_MAX, SMP_MIN, 17'sd16384);
    queue_frame(SMP_MIN, SMP_MAX, SMP_MAX, 17'sd49152);
    queue_frame(SMP_MAX, 0, SMP_MIN, -17'sd1);
    queue_frame(SMP_MIN, 0, SMP_MAX, -17'sd65536);
    wait_drained();

    write_reg(CFG_BALANCE_SOURCE, CFG_DATA_BITS'(SRC_BIPOLAR));
    @(negedge clk_i);
    queue_frame(SMP_MAX, SMP_MIN, SMP_MAX, -17'sd32768);
    queue_frame(SMP_MAX, SMP_MIN, SMP_MIN, 17'sd32767);
    queue_frame(SMP_MIN, SMP_MAX, SMP_MIN, 17'sd0);
    queue_frame(SMP_MAX, SMP_MAX, SMP_MAX, -17'sd1);
    queue_frame(SMP_MIN, SMP_MIN, SMP_MIN, 17'sd65535);
    queue_frame(SMP_MAX, SMP_MIN, SMP_MAX, 17'sd32768);
    wait_drained();

    // The spare source code falls back to the fixed register.
    write_reg(CFG_FIXED_BALANCE, '0);
    write_reg(CFG_BALANCE_SOURCE, {{(CFG_DATA_BITS-SRC_BITS){1'b1}}, SRC_SPARE});
    @(negedge clk_i);
    queue_frame(SMP_MAX, SMP_MIN, SMP_MIN, 17'sd40000);
    queue_frame(SMP_MIN, SMP_MAX, SMP_MAX, -17'sd7);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      src = (ph < 8) ? SRC_BITS'(ph) : SRC_BITS'($urandom_range(0, 3));
      case (ph)
        0: bal = '0;
        3: bal = '1;
        4: bal = BAL_RESET;
        7: bal = 1;
        default: bal = BAL_BITS'($urandom());
      endcase
      write_reg(CFG_FIXED_BALANCE, bal);
      write_reg(CFG_BALANCE_SOURCE, {(CFG_DATA_BITS-SRC_BITS)'($urandom()), src});
      @(negedge clk_i);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        queue_frame(rand_sample(), rand_sample(), rand_sample(), rand_mod(src));
      end
      wait_drained();
    end

    $display("Sent %0d sample frames over %0d register writes; %0d mixed samples checked.",
             items_taken, cfg_writes, results_seen);
    $display("Covered fixed, unipolar, bipolar and spare balance sources with edge balances.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
